FILE: hdl/vcbd_pkg.sv
// Shared definitions for the video chip bus decoder: request codes, memory map
// addresses, internal operation codes and the queue entry type.
// No dependencies.
package vcbd_pkg;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 16;
    localparam int REQ_W  = 3;

    // Largest RAM needs 22 index bits; the ROM never needs more.
    localparam int IX_W = 22;

    // Smallest memory size is 2**16 bytes; this bounds the reciprocal and quotient widths.
    localparam int MIN_MEM_LOG2 = 16;

    localparam int BOOT_CNT_W = 3;

    localparam int QUEUE_DEPTH = 2;

    localparam int DEF_RAM_BYTES       = 4194304;
    localparam int DEF_ROM_BYTES       = 1048576;
    localparam int DEF_BOOT_WORD_READS = 4;

    // Request types on the bus side
    localparam logic [REQ_W-1:0] REQ_RD_BYTE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RD_WORD  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WR_BYTE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WR_WORD  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_ROM_LOAD = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STATUS   = 3'd5;

    // Memory map
    localparam logic [ADDR_W-1:0] ROM_BASE  = 24'h400000;
    localparam logic [ADDR_W-1:0] ROM_END   = 24'h4FFC00;
    localparam logic [ADDR_W-1:0] CSR2_WORD = 24'h4FFFE0;
    localparam logic [ADDR_W-1:0] CSR2_BYTE = 24'h4FFFE1;
    localparam logic [ADDR_W-1:0] CSR1_WORD = 24'h4FFFF0;
    localparam logic [ADDR_W-1:0] CSR1_BYTE = 24'h4FFFF1;
    localparam logic [ADDR_W-1:0] WIN_BASE  = 24'h4FFFE0;
    localparam logic [ADDR_W-1:0] WIN_END   = 24'h500000;

    localparam int WIN_DEPTH = 32;
    localparam int WIN_IX_W  = 5;

    // Operations handed from the decode side to the execute side
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_ERR      = 4'd1;
    localparam t_op OP_RAM_RD_B = 4'd2;
    localparam t_op OP_RAM_RD_W = 4'd3;
    localparam t_op OP_ROM_RD_B = 4'd4;
    localparam t_op OP_ROM_RD_W = 4'd5;
    localparam t_op OP_CSR2_RD  = 4'd6;
    localparam t_op OP_CSR1_RD  = 4'd7;
    localparam t_op OP_RAM_WR_B = 4'd8;
    localparam t_op OP_RAM_WR_W = 4'd9;
    localparam t_op OP_WIN_WR_B = 4'd10;
    localparam t_op OP_WIN_WR_W = 4'd11;
    localparam t_op OP_ROM_LOAD = 4'd12;
    localparam t_op OP_STATUS   = 4'd13;

    typedef struct packed {
        t_op               op;
        logic [IX_W-1:0]   ix;
        logic [DATA_W-1:0] data;
    } t_entry;

endpackage

FILE: hdl/vcbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vcbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/vcbd_queue.sv
// Short in-order queue of decoded operations between decode and execute.
// Depends on vcbd_pkg.
module vcbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  vcbd_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output vcbd_pkg::t_entry o_entry,
    output logic            o_empty
);
    import vcbd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_entry             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    assign o_entry = r_slot[r_rptr];
    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);

endmodule

FILE: hdl/vcbd_front.sv
// Decode side: accepts bus beats, classifies them against the memory map,
// tracks the boot word reads and reduces the memory index modulo the RAM or
// ROM size in a short pipeline. Depends on vcbd_pkg.
module vcbd_front #(
    parameter int RAM_BYTES       = vcbd_pkg::DEF_RAM_BYTES,
    parameter int ROM_BYTES       = vcbd_pkg::DEF_ROM_BYTES,
    parameter int BOOT_WORD_READS = vcbd_pkg::DEF_BOOT_WORD_READS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vcbd_pkg::REQ_W-1:0]  i_req_type,
    input  logic [vcbd_pkg::ADDR_W-1:0] i_address,
    input  logic [vcbd_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_push,
    output vcbd_pkg::t_entry            o_entry,
    input  logic                        i_full
);
    import vcbd_pkg::*;

    // Reciprocal multiply: q = floor(x * floor(2^32 / N) / 2^32) is at most one
    // below x / N for any 24-bit x, so a single correction step follows.
    localparam int RECIP_SHIFT = 32;
    localparam int M_W         = RECIP_SHIFT - MIN_MEM_LOG2 + 1;
    localparam int PROD_W      = ADDR_W + M_W;
    localparam int Q_W         = ADDR_W - MIN_MEM_LOG2;
    localparam logic [63:0] RAM_M64 = 64'h1_0000_0000 / RAM_BYTES;
    localparam logic [63:0] ROM_M64 = 64'h1_0000_0000 / ROM_BYTES;
    localparam logic [M_W-1:0]    RAM_M = RAM_M64[M_W-1:0];
    localparam logic [M_W-1:0]    ROM_M = ROM_M64[M_W-1:0];
    localparam logic [ADDR_W-1:0] RAM_N = ADDR_W'(RAM_BYTES);
    localparam logic [ADDR_W-1:0] ROM_N = ADDR_W'(ROM_BYTES);

    logic                  accept;
    logic [BOOT_CNT_W-1:0] r_boot_cnt, n_boot_cnt;
    logic                  boot_active;

    t_op                   dec_op;
    logic [ADDR_W-1:0]     dec_x;
    logic                  dec_rom;

    // Stage 1: decoded beat
    logic                  r_s1_v;
    t_op                   r_s1_op;
    logic [ADDR_W-1:0]     r_s1_x;
    logic                  r_s1_rom;
    logic [DATA_W-1:0]     r_s1_data;
    // Stage 2: quotient estimate
    logic                  r_s2_v;
    t_op                   r_s2_op;
    logic [ADDR_W-1:0]     r_s2_x;
    logic                  r_s2_rom;
    logic [DATA_W-1:0]     r_s2_data;
    logic [Q_W-1:0]        r_s2_q;
    // Stage 3: quotient times modulus
    logic                  r_s3_v;
    t_op                   r_s3_op;
    logic [ADDR_W-1:0]     r_s3_x;
    logic                  r_s3_rom;
    logic [DATA_W-1:0]     r_s3_data;
    logic [ADDR_W-1:0]     r_s3_t;

    logic                  rdy1, rdy2, rdy3;
    logic                  mv2, mv3;
    logic [PROD_W-1:0]     prod;
    logic [ADDR_W-1:0]     prod_n;
    logic [ADDR_W-1:0]     rem;
    logic [ADDR_W-1:0]     rem_fix;
    logic [ADDR_W-1:0]     s3_n;

    assign boot_active = (r_boot_cnt < BOOT_CNT_W'(BOOT_WORD_READS));

    always_comb begin
        dec_op  = OP_NONE;
        dec_x   = i_address;
        dec_rom = 1'b0;
        unique case (i_req_type) inside
            REQ_RD_BYTE: begin
                if (i_address < ROM_BASE) begin
                    dec_op = OP_RAM_RD_B;
                end else if (i_address < ROM_END) begin
                    dec_op  = OP_ROM_RD_B;
                    dec_x   = i_address - ROM_BASE;
                    dec_rom = 1'b1;
                end else if (i_address == CSR2_BYTE) begin
                    dec_op = OP_CSR2_RD;
                end else if (i_address == CSR1_BYTE) begin
                    dec_op = OP_CSR1_RD;
                end else begin
                    dec_op = OP_ERR;
                end
            end
            REQ_RD_WORD: begin
                if (boot_active) begin
                    dec_op  = OP_ROM_RD_W;
                    dec_rom = 1'b1;
                end else if (i_address < ROM_BASE) begin
                    dec_op = OP_RAM_RD_W;
                end else if (i_address < ROM_END) begin
                    dec_op  = OP_ROM_RD_W;
                    dec_x   = i_address - ROM_BASE;
                    dec_rom = 1'b1;
                end else if (i_address == CSR2_WORD) begin
                    dec_op = OP_CSR2_RD;
                end else if (i_address == CSR1_WORD) begin
                    dec_op = OP_CSR1_RD;
                end else begin
                    dec_op = OP_ERR;
                end
            end
            REQ_WR_BYTE, REQ_WR_WORD: begin
                if (i_address < ROM_BASE) begin
                    dec_op = (i_req_type == REQ_WR_BYTE) ? OP_RAM_WR_B : OP_RAM_WR_W;
                end else if (i_address >= WIN_BASE && i_address < WIN_END) begin
                    // The window index is below any modulus, so reduction keeps it.
                    dec_op = (i_req_type == REQ_WR_BYTE) ? OP_WIN_WR_B : OP_WIN_WR_W;
                    dec_x  = {{(ADDR_W-WIN_IX_W){1'b0}}, i_address[WIN_IX_W-1:0]};
                end else begin
                    dec_op = OP_ERR;
                end
            end
            REQ_ROM_LOAD: begin
                dec_op  = OP_ROM_LOAD;
                dec_rom = 1'b1;
            end
            REQ_STATUS: begin
                dec_op = OP_STATUS;
            end
            default: begin
                dec_op = OP_NONE;
            end
        endcase
    end

    // Pipeline flow control
    assign rdy3    = !r_s3_v || !i_full;
    assign mv3     = r_s2_v && rdy3;
    assign rdy2    = !r_s2_v || rdy3;
    assign mv2     = r_s1_v && rdy2;
    assign rdy1    = !r_s1_v || rdy2;
    assign o_ready = rdy1;
    assign accept  = i_valid && rdy1;

    always_comb begin
        n_boot_cnt = r_boot_cnt;
        if (accept && i_req_type == REQ_RD_WORD && boot_active) begin
            n_boot_cnt = r_boot_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_cnt <= '0;
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_s3_v     <= 1'b0;
        end else begin
            r_boot_cnt <= n_boot_cnt;
            if (rdy1) begin
                r_s1_v <= i_valid;
            end
            if (rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (rdy3) begin
                r_s3_v <= r_s2_v;
            end
        end
    end

    assign prod   = PROD_W'(r_s1_x) * PROD_W'(r_s1_rom ? ROM_M : RAM_M);
    assign prod_n = ADDR_W'(r_s2_q) * (r_s2_rom ? ROM_N : RAM_N);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op   <= dec_op;
            r_s1_x    <= dec_x;
            r_s1_rom  <= dec_rom;
            r_s1_data <= i_write_data;
        end
        if (mv2) begin
            r_s2_op   <= r_s1_op;
            r_s2_x    <= r_s1_x;
            r_s2_rom  <= r_s1_rom;
            r_s2_data <= r_s1_data;
            r_s2_q    <= prod[RECIP_SHIFT +: Q_W];
        end
        if (mv3) begin
            r_s3_op   <= r_s2_op;
            r_s3_x    <= r_s2_x;
            r_s3_rom  <= r_s2_rom;
            r_s3_data <= r_s2_data;
            r_s3_t    <= prod_n;
        end
    end

    assign s3_n    = r_s3_rom ? ROM_N : RAM_N;
    assign rem     = r_s3_x - r_s3_t;
    assign rem_fix = (rem >= s3_n) ? rem - s3_n : rem;

    assign o_push        = r_s3_v && !i_full;
    assign o_entry.op    = r_s3_op;
    assign o_entry.ix    = rem_fix[IX_W-1:0];
    assign o_entry.data  = r_s3_data;

endmodule

FILE: hdl/vcbd_back.sv
// Execute side: takes decoded operations from the queue, runs them against
// RAM, ROM, the status bytes and the register window, and holds the result
// beat. Depends on vcbd_pkg and vcbd_ram.
module vcbd_back #(
    parameter int RAM_BYTES = vcbd_pkg::DEF_RAM_BYTES,
    parameter int ROM_BYTES = vcbd_pkg::DEF_ROM_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vcbd_pkg::t_entry            i_entry,
    input  logic                        i_empty,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vcbd_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_bus_error
);
    import vcbd_pkg::*;

    localparam int RAM_AW = $clog2(RAM_BYTES);
    localparam int ROM_AW = $clog2(ROM_BYTES);
    localparam logic [IX_W-1:0] RAM_LAST = IX_W'(RAM_BYTES - 1);
    localparam logic [IX_W-1:0] ROM_LAST = IX_W'(ROM_BYTES - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_BYTE = 3'd2;
    localparam logic [2:0] ST_HI   = 3'd3;
    localparam logic [2:0] ST_LO   = 3'd4;
    localparam logic [2:0] ST_WR1  = 3'd5;

    logic [2:0]        r_state, n_state;
    t_op               r_op;
    logic [IX_W-1:0]   r_ix0;
    logic [IX_W-1:0]   r_ix1;
    logic [DATA_W-1:0] r_data;
    logic [7:0]        r_hi;
    logic [7:0]        r_status_one, n_status_one;
    logic [7:0]        r_status_two, n_status_two;
    logic [DATA_W-1:0] r_window [WIN_DEPTH];
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    logic              r_out_err, n_out_err;

    logic              is_rom;
    logic [IX_W-1:0]   ix_last;
    logic [IX_W-1:0]   ix_next;
    logic              win_we;
    logic [IX_W-1:0]   mem_raddr;
    logic [7:0]        rd_byte;

    logic              ram_we;
    logic [IX_W-1:0]   ram_waddr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;
    logic              rom_we;
    logic [7:0]        rom_rdata;

    assign o_pop = (r_state == ST_IDLE) && !i_empty && !r_out_valid;

    // Second byte of a word wraps at the end of its memory.
    assign ix_last = (i_entry.op == OP_ROM_RD_W) ? ROM_LAST : RAM_LAST;
    assign ix_next = (i_entry.ix == ix_last) ? '0 : i_entry.ix + 1'b1;

    assign is_rom    = (r_op == OP_ROM_RD_B) || (r_op == OP_ROM_RD_W);
    assign rd_byte   = is_rom ? rom_rdata : ram_rdata;
    assign mem_raddr = (r_state == ST_HI) ? r_ix1 : r_ix0;

    always_comb begin
        n_state      = r_state;
        n_status_one = r_status_one;
        n_status_two = r_status_two;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_err    = r_out_err;
        ram_we       = 1'b0;
        ram_waddr    = r_ix0;
        ram_wdata    = r_data[15:8];
        rom_we       = 1'b0;
        win_we       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state    = ST_IDLE;
                n_out_data = '0;
                n_out_err  = 1'b0;
                unique case (r_op) inside
                    OP_RAM_RD_B, OP_ROM_RD_B: begin
                        n_state = ST_BYTE;
                    end
                    OP_RAM_RD_W, OP_ROM_RD_W: begin
                        n_state = ST_HI;
                    end
                    OP_RAM_WR_W: begin
                        ram_we  = 1'b1;
                        n_state = ST_WR1;
                    end
                    OP_RAM_WR_B: begin
                        ram_we      = 1'b1;
                        ram_wdata   = r_data[7:0];
                        n_out_valid = 1'b1;
                    end
                    OP_ROM_LOAD: begin
                        rom_we      = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    OP_WIN_WR_B, OP_WIN_WR_W: begin
                        win_we      = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    OP_CSR2_RD: begin
                        n_out_data   = {8'h00, r_status_two};
                        n_status_two = '0;
                        n_out_valid  = 1'b1;
                    end
                    OP_CSR1_RD: begin
                        n_out_data  = {8'h00, r_status_one};
                        n_out_valid = 1'b1;
                    end
                    OP_STATUS: begin
                        n_status_two = r_data[15:8];
                        n_status_one = r_data[7:0];
                        n_out_valid  = 1'b1;
                    end
                    OP_ERR: begin
                        n_out_err   = 1'b1;
                        n_out_valid = 1'b1;
                    end
                    default: begin
                        n_out_valid = 1'b1;
                    end
                endcase
            end
            ST_BYTE: begin
                n_out_data  = {8'h00, rd_byte};
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_HI: begin
                n_state = ST_LO;
            end
            ST_LO: begin
                n_out_data  = {r_hi, rd_byte};
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_WR1: begin
                ram_we      = 1'b1;
                ram_waddr   = r_ix1;
                ram_wdata   = r_data[7:0];
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_status_one <= '0;
            r_status_two <= '0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_status_one <= n_status_one;
            r_status_two <= n_status_two;
            r_out_valid  <= n_out_valid;
            if (win_we) begin
                if (r_op == OP_WIN_WR_W) begin
                    r_window[r_ix0[WIN_IX_W-1:0]] <= r_data;
                end else if (r_ix0[0]) begin
                    r_window[r_ix0[WIN_IX_W-1:0]][7:0] <= r_data[7:0];
                end else begin
                    r_window[r_ix0[WIN_IX_W-1:0]][15:8] <= r_data[7:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op   <= i_entry.op;
            r_ix0  <= i_entry.ix;
            r_ix1  <= ix_next;
            r_data <= i_entry.data;
        end
        if (r_state == ST_HI) begin
            r_hi <= rd_byte;
        end
        r_out_data <= n_out_data;
        r_out_err  <= n_out_err;
    end

    vcbd_ram #(
        .WIDTH (8),
        .DEPTH (RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[RAM_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (mem_raddr[RAM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    vcbd_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_we),
        .i_waddr (r_ix0[ROM_AW-1:0]),
        .i_wdata (r_data[7:0]),
        .i_raddr (mem_raddr[ROM_AW-1:0]),
        .o_rdata (rom_rdata)
    );

    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_bus_error = r_out_err;

endmodule

FILE: hdl/video_chip_bus_decoder_core.sv
// Bus decoder for a video controller's memory map. One result beat is
// returned per accepted request beat, in order. A three-stage decode pipeline
// classifies each access and reduces its memory index; a two-entry queue then
// feeds an execute sequencer that owns RAM, ROM, the status bytes and the
// register window. The execute sequencer sets the rate: status, register
// window, ROM load, byte writes and errors need only the execute state; byte
// reads add a byte state, word writes a second write state and word reads a
// high and a low byte state. This is because RAM and ROM are byte-wide
// memories with one read port and a registered read, and the next operation
// is only taken from the queue once the previous result beat has left. The
// first BOOT_WORD_READS word reads after reset read the ROM at the raw
// address, reduced modulo the ROM size.
// Depends on vcbd_pkg, vcbd_front, vcbd_queue and vcbd_back.
module video_chip_bus_decoder_core #(
    parameter int RAM_BYTES       = vcbd_pkg::DEF_RAM_BYTES,
    parameter int ROM_BYTES       = vcbd_pkg::DEF_ROM_BYTES,
    parameter int BOOT_WORD_READS = vcbd_pkg::DEF_BOOT_WORD_READS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [vcbd_pkg::REQ_W-1:0]  i_req_type,
    input  logic [vcbd_pkg::ADDR_W-1:0] i_address,
    input  logic [vcbd_pkg::DATA_W-1:0] i_write_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vcbd_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_bus_error
);
    import vcbd_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry push_entry;
    t_entry pop_entry;

    vcbd_front #(
        .RAM_BYTES       (RAM_BYTES),
        .ROM_BYTES       (ROM_BYTES),
        .BOOT_WORD_READS (BOOT_WORD_READS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_push       (push),
        .o_entry      (push_entry),
        .i_full       (full)
    );

    vcbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_entry (pop_entry),
        .o_empty (empty)
    );

    vcbd_back #(
        .RAM_BYTES (RAM_BYTES),
        .ROM_BYTES (ROM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_entry     (pop_entry),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_data (o_read_data),
        .o_bus_error (o_bus_error)
    );

endmodule

FILE: verif/tb_video_chip_bus_decoder_core.sv
// Self-checking testbench for video_chip_bus_decoder_core: a directed table, then
// random bus traffic, with every result beat checked against a fixed row result
// or an in-bench predictor. Depends on vcbd_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_video_chip_bus_decoder_core;
    import vcbd_pkg::*;

    localparam int RAM_BYTES       = DEF_RAM_BYTES;
    localparam int ROM_BYTES       = DEF_ROM_BYTES;
    localparam int BOOT_WORD_READS = DEF_BOOT_WORD_READS;
    localparam int ROM_WINDOW      = ROM_END - ROM_BASE;

    localparam logic [REQ_W-1:0] REQ_SPARE_6 = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS = 1350;
    localparam int IDLE_PCT     = 11;
    localparam int CALM_FROM    = 800;
    localparam int CALM_TO      = 1000;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int N_ROWS       = 27;

    typedef struct packed {
        logic [DATA_W-1:0] rd;
        logic              err;
    } t_resp;

    typedef struct packed {
        logic              used;
        t_resp             r;
    } t_fixed;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              used;
        logic [DATA_W-1:0] rd;
        logic              err;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [REQ_W-1:0]  i_req_type;
    logic [ADDR_W-1:0] i_address;
    logic [DATA_W-1:0] i_write_data;
    logic              o_valid;
    logic              i_ready;
    logic [DATA_W-1:0] o_read_data;
    logic              o_bus_error;

    video_chip_bus_decoder_core #(
        .RAM_BYTES       (RAM_BYTES),
        .ROM_BYTES       (ROM_BYTES),
        .BOOT_WORD_READS (BOOT_WORD_READS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_data  (o_read_data),
        .o_bus_error  (o_bus_error)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor state, advanced in acceptance order.
    logic [7:0]        ram_img [int];
    logic [7:0]        rom_img [int];
    logic [DATA_W-1:0] win_img [WIN_DEPTH];
    logic [7:0]        csr1_img;
    logic [7:0]        csr2_img;
    int                boot_reads;

    // What the stimulus side knows has been stored, advanced in issue order.
    bit                gen_ram_ok [int];
    bit                gen_rom_ok [int];
    int unsigned       gen_ram_list [$];
    int unsigned       gen_rom_list [$];

    t_resp             bus_resp_q [$];
    t_fixed            fixed_resp_q [$];

    int n_fail       = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_items      = 0;
    int stall_cycles = 0;

    t_row dir_rows [N_ROWS] = '{
        // ROM contents for the boot reads and the top of the ROM range
        '{REQ_ROM_LOAD, 24'h000000, 16'h00A5, 1'b1, 16'h0000, 1'b0},
        '{REQ_ROM_LOAD, 24'h000001, 16'hFF5A, 1'b1, 16'h0000, 1'b0},
        '{REQ_ROM_LOAD, 24'hFFFFFF, 16'h003C, 1'b1, 16'h0000, 1'b0},
        '{REQ_ROM_LOAD, 24'h4FFBFF, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{REQ_ROM_LOAD, 24'h0FFC00, 16'h00FF, 1'b1, 16'h0000, 1'b0},
        // Boot word reads ignore the decode and wrap within the ROM.
        '{REQ_RD_WORD,  24'h000000, 16'h0000, 1'b1, 16'hA55A, 1'b0},
        '{REQ_RD_WORD,  24'hFFFFFF, 16'h0000, 1'b1, 16'h3CA5, 1'b0},
        '{REQ_RD_WORD,  24'h4FFBFF, 16'h0000, 1'b1, 16'h00FF, 1'b0},
        '{REQ_RD_WORD,  24'h0FFFFF, 16'h0000, 1'b1, 16'h3CA5, 1'b0},
        '{REQ_RD_WORD,  24'h4FFBFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
        // Status bytes; reading CSR2 clears it.
        '{REQ_STATUS,   24'h000000, 16'hABCD, 1'b1, 16'h0000, 1'b0},
        '{REQ_RD_BYTE,  CSR2_BYTE,  16'h0000, 1'b1, 16'h00AB, 1'b0},
        '{REQ_RD_WORD,  CSR2_WORD,  16'h0000, 1'b1, 16'h0000, 1'b0},
        '{REQ_RD_WORD,  CSR1_WORD,  16'h0000, 1'b1, 16'h00CD, 1'b0},
        '{REQ_RD_BYTE,  CSR1_BYTE,  16'h0000, 1'b1, 16'h00CD, 1'b0},
        // RAM word across the top edge and a byte beside its wrapped half
        '{REQ_WR_WORD,  24'h3FFFFF, 16'hBEEF, 1'b1, 16'h0000, 1'b0},
        '{REQ_RD_WORD,  24'h3FFFFF, 16'h0000, 1'b1, 16'hBEEF, 1'b0},
        '{REQ_WR_BYTE,  24'h000001, 16'hFF77, 1'b1, 16'h0000, 1'b0},
        '{REQ_RD_WORD,  24'h000000, 16'h0000, 1'b0, 16'h0000, 1'b0},
        '{REQ_RD_BYTE,  24'h4FFC00, 16'h0000, 1'b1, 16'h0000, 1'b1},
        '{REQ_WR_WORD,  24'h400000, 16'hFFFF, 1'b1, 16'h0000, 1'b1},
        '{REQ_WR_BYTE,  24'h4FFFE0, 16'h0012, 1'b1, 16'h0000, 1'b0},
        '{REQ_WR_WORD,  24'h4FFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0},
        '{REQ_RD_BYTE,  24'h4FFFE0, 16'h0000, 1'b1, 16'h0000, 1'b1},
        '{REQ_WR_BYTE,  24'h500000, 16'h0000, 1'b1, 16'h0000, 1'b1},
        '{REQ_SPARE_6,  24'h000000, 16'h0000, 1'b1, 16'h0000, 1'b0},
        '{REQ_SPARE_7,  24'hFFFFFF, 16'hFFFF, 1'b1, 16'h0000, 1'b0}
    };

    function automatic t_resp bus_access(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr,
                                         logic [DATA_W-1:0] data);
        t_resp       r;
        int unsigned a;
        int unsigned o;
        int unsigned w;
        r = '0;
        a = addr;
        o = a - ROM_BASE;
        w = (a - WIN_BASE) % WIN_DEPTH;
        case (req)
            REQ_RD_BYTE: begin
                if (addr < ROM_BASE) r.rd = {8'h00, ram_img[a % RAM_BYTES]};
                else if (addr < ROM_END) r.rd = {8'h00, rom_img[o % ROM_BYTES]};
                else if (addr == CSR2_BYTE) begin
                    r.rd = {8'h00, csr2_img};
                    csr2_img = '0;
                end else if (addr == CSR1_BYTE) r.rd = {8'h00, csr1_img};
                else r.err = 1'b1;
            end
            REQ_RD_WORD: begin
                if (boot_reads < BOOT_WORD_READS) begin
                    boot_reads++;
                    r.rd = {rom_img[a % ROM_BYTES], rom_img[(a + 1) % ROM_BYTES]};
                end else if (addr < ROM_BASE) begin
                    r.rd = {ram_img[a % RAM_BYTES], ram_img[(a + 1) % RAM_BYTES]};
                end else if (addr < ROM_END) begin
                    r.rd = {rom_img[o % ROM_BYTES], rom_img[(o + 1) % ROM_BYTES]};
                end else if (addr == CSR2_WORD) begin
                    r.rd = {8'h00, csr2_img};
                    csr2_img = '0;
                end else if (addr == CSR1_WORD) r.rd = {8'h00, csr1_img};
                else r.err = 1'b1;
            end
            REQ_WR_BYTE: begin
                if (addr < ROM_BASE) ram_img[a % RAM_BYTES] = data[7:0];
                else if (addr >= WIN_BASE && addr < WIN_END) begin
                    // Even addresses land in the high half of the entry.
                    if (addr[0]) win_img[w][7:0] = data[7:0];
                    else win_img[w][15:8] = data[7:0];
                end else r.err = 1'b1;
            end
            REQ_WR_WORD: begin
                if (addr < ROM_BASE) begin
                    ram_img[a % RAM_BYTES]       = data[15:8];
                    ram_img[(a + 1) % RAM_BYTES] = data[7:0];
                end else if (addr >= WIN_BASE && addr < WIN_END) win_img[w] = data;
                else r.err = 1'b1;
            end
            REQ_ROM_LOAD: rom_img[a % ROM_BYTES] = data[7:0];
            REQ_STATUS: begin
                csr2_img = data[15:8];
                csr1_img = data[7:0];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void mark_ram(int unsigned a);
        if (!gen_ram_ok.exists(a)) begin
            gen_ram_ok[a] = 1'b1;
            gen_ram_list.push_back(a);
        end
    endfunction

    function automatic void mark_rom(int unsigned o);
        if (!gen_rom_ok.exists(o)) begin
            gen_rom_ok[o] = 1'b1;
            gen_rom_list.push_back(o);
        end
    endfunction

    function automatic void track_stored(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
        int unsigned a;
        a = addr;
        if ((req == REQ_WR_BYTE || req == REQ_WR_WORD) && addr < ROM_BASE) begin
            mark_ram(a % RAM_BYTES);
            if (req == REQ_WR_WORD) mark_ram((a + 1) % RAM_BYTES);
        end else if (req == REQ_ROM_LOAD) begin
            mark_rom(a % ROM_BYTES);
        end
    endfunction

    // True unless a byte or word read touches a memory byte never stored.
    function automatic bit readable(logic [REQ_W-1:0] req, logic [ADDR_W-1:0] addr);
        int unsigned a;
        int unsigned o;
        bit          word;
        a    = addr;
        o    = a - ROM_BASE;
        word = (req == REQ_RD_WORD);
        if (req != REQ_RD_BYTE && !word) return 1'b1;
        if (addr < ROM_BASE)
            return gen_ram_ok.exists(a % RAM_BYTES) &&
                   (!word || gen_ram_ok.exists((a + 1) % RAM_BYTES));
        if (addr < ROM_END)
            return gen_rom_ok.exists(o % ROM_BYTES) &&
                   (!word || gen_rom_ok.exists((o + 1) % ROM_BYTES));
        return 1'b1;
    endfunction

    function automatic bit ram_word_at(output int unsigned a);
        int unsigned b;
        b = gen_ram_list[$urandom_range(gen_ram_list.size() - 1)];
        a = b;
        if (gen_ram_ok.exists((b + 1) % RAM_BYTES)) return 1'b1;
        a = (b + RAM_BYTES - 1) % RAM_BYTES;
        return gen_ram_ok.exists(a);
    endfunction

    function automatic bit rom_word_at(output int unsigned o);
        int unsigned b;
        b = gen_rom_list[$urandom_range(gen_rom_list.size() - 1)];
        o = b;
        if (b < ROM_WINDOW && gen_rom_ok.exists((b + 1) % ROM_BYTES)) return 1'b1;
        o = (b + ROM_BYTES - 1) % ROM_BYTES;
        return o < ROM_WINDOW && gen_rom_ok.exists(o);
    endfunction

    function automatic int unsigned pick_ram_addr();
        case ($urandom_range(2))
            0: return $urandom_range(RAM_BYTES - 1);
            1: return $urandom_range(255);
            default: return RAM_BYTES - 1 - $urandom_range(255);
        endcase
    endfunction

    function automatic bit calm_stretch();
        return n_accepted >= CALM_FROM && n_accepted < CALM_TO;
    endfunction

    // Entered and left at a falling edge; returns once the beat is taken.
    task automatic send_beat(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic fixed,
                             input t_resp fixed_resp);
        t_fixed f;
        while (!calm_stretch() && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_req_type   <= req;
        i_address    <= addr;
        i_write_data <= data;
        f.used = fixed;
        f.r    = fixed_resp;
        fixed_resp_q.push_back(f);
        track_stored(req, addr);
        if (req <= REQ_STATUS) n_items++;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic issue(input logic [REQ_W-1:0] req, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data);
        send_beat(req, addr, data, 1'b0, '0);
    endtask

    always @(posedge i_clk) begin : bus_monitor
        t_resp  want;
        t_fixed f;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_results++;
                if (bus_resp_q.size() == 0) begin
                    $error("result beat with nothing expected: read_data %h, bus_error %b",
                           o_read_data, o_bus_error);
                    n_fail++;
                end else begin
                    want = bus_resp_q.pop_front();
                    if (o_read_data !== want.rd) begin
                        $error("read_data: expected %h, actual %h", want.rd, o_read_data);
                        n_fail++;
                    end
                    if (o_bus_error !== want.err) begin
                        $error("bus_error: expected %b, actual %b", want.err, o_bus_error);
                        n_fail++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                want = bus_access(i_req_type, i_address, i_write_data);
                f    = fixed_resp_q.pop_front();
                if (f.used) want = f.r;
                bus_resp_q.push_back(want);
                n_accepted++;
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
    end

    // Result side: random stalls, a quiet stretch, and one long hold-off that backs
    // up the pipeline and queue until the request side stalls.
    initial begin : result_sink
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && n_accepted >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (!i_rst_n || calm_stretch()) begin
                i_ready <= i_rst_n;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin : stimulus
        int          first;
        int unsigned a;
        int unsigned o;
        logic [REQ_W-1:0]  req;
        logic [ADDR_W-1:0] addr;
        csr1_img     = '0;
        csr2_img     = '0;
        boot_reads   = 0;
        foreach (win_img[k]) win_img[k] = '0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = '0;
        i_address    = '0;
        i_write_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k])
            send_beat(dir_rows[k].req, dir_rows[k].addr, dir_rows[k].data, dir_rows[k].used,
                      {dir_rows[k].rd, dir_rows[k].err});

        first = n_items;
        while (n_items - first < RANDOM_ITEMS) begin
            case ($urandom_range(9))
                0: issue(REQ_WR_BYTE, 24'(pick_ram_addr()), 16'($urandom));
                1: issue(REQ_WR_WORD, 24'(pick_ram_addr()), 16'($urandom));
                2: begin
                    a = gen_ram_list[$urandom_range(gen_ram_list.size() - 1)];
                    issue(REQ_RD_BYTE, 24'(a), 16'($urandom));
                end
                3: begin
                    if (ram_word_at(a)) issue(REQ_RD_WORD, 24'(a), 16'($urandom));
                    else issue(REQ_WR_WORD, 24'(pick_ram_addr()), 16'($urandom));
                end
                4: begin
                    // Load a byte pair so that later word reads have both halves.
                    o = $urandom_range(ROM_WINDOW - 2);
                    issue(REQ_ROM_LOAD, {4'($urandom), 20'(o)}, 16'($urandom));
                    issue(REQ_ROM_LOAD, {4'($urandom), 20'(o + 1)}, 16'($urandom));
                end
                5: begin
                    if ($urandom_range(1) == 0) begin
                        o = gen_rom_list[$urandom_range(gen_rom_list.size() - 1)];
                        if (o < ROM_WINDOW) issue(REQ_RD_BYTE, 24'(ROM_BASE + o), 16'($urandom));
                    end else if (rom_word_at(o)) begin
                        issue(REQ_RD_WORD, 24'(ROM_BASE + o), 16'($urandom));
                    end
                end
                6: issue(REQ_STATUS, 24'($urandom), 16'($urandom));
                7: begin
                    case ($urandom_range(3))
                        0: issue(REQ_RD_BYTE, CSR2_BYTE, 16'($urandom));
                        1: issue(REQ_RD_WORD, CSR2_WORD, 16'($urandom));
                        2: issue(REQ_RD_BYTE, CSR1_BYTE, 16'($urandom));
                        default: issue(REQ_RD_WORD, CSR1_WORD, 16'($urandom));
                    endcase
                end
                8: begin
                    addr = WIN_BASE + 24'($urandom_range(WIN_DEPTH - 1));
                    req  = ($urandom_range(1) == 0) ? REQ_WR_BYTE : REQ_WR_WORD;
                    issue(req, addr, 16'($urandom));
                end
                default: begin
                    // Any type at any address; reads of never-stored memory are
                    // pushed up into the unmapped space instead.
                    req  = 3'($urandom_range(7));
                    addr = 24'($urandom);
                    if (!readable(req, addr)) addr[23] = 1'b1;
                    issue(req, addr, 16'($urandom));
                end
            endcase
        end
        i_valid <= 1'b0;

        while (bus_resp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d request beats and %0d result beats over %0d RAM and %0d ROM bytes,",
                 n_accepted, n_results, gen_ram_list.size(), gen_rom_list.size());
        $display("with boot reads, status clears, edge wraps, bus errors and a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (n_fail == 0 && bus_resp_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/vcbd_pkg.sv
hdl/vcbd_ram.sv
hdl/vcbd_queue.sv
hdl/vcbd_front.sv
hdl/vcbd_back.sv
hdl/video_chip_bus_decoder_core.sv
verif/tb_video_chip_bus_decoder_core.sv
